[src/hcp_pkg.sv]
package hcp_pkg;

  localparam int SYMBOL_BITS  = 8;
  localparam int TABLE_DEPTH  = 1 << SYMBOL_BITS;
  localparam int CODE_W       = 16;
  localparam int LEN_W        = 5;
  localparam int MAX_CODE_LEN = 16;
  localparam int PEND_W       = 7;
  localparam int CNT_W        = 3;
  localparam int ACC_W        = PEND_W + MAX_CODE_LEN;

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_ENCODE = 2'd1;
  localparam logic [1:0] MODE_FLUSH  = 2'd2;

  // one looked-up table entry
  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } entry_t;

endpackage

[src/hcp_table.sv]
module hcp_table (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_en_i,
  input  logic [7:0]                 wr_sym_i,
  input  logic [15:0]                wr_code_i,
  input  logic [4:0]                 wr_len_i,
  input  logic                       rd_en_i,
  input  logic [7:0]                 rd_sym_i,
  output hcp_pkg::entry_t            rd_o
);
  import hcp_pkg::*;

  logic [CODE_W+LEN_W-1:0]  mem_q [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]   valid_q;
  logic [SYMBOL_BITS-1:0]   wr_idx, rd_idx;
  logic [LEN_W-1:0]         len_sat;
  logic [CODE_W-1:0]        code_msk;
  entry_t                   rd_q;

  assign wr_idx = wr_sym_i[SYMBOL_BITS-1:0];
  assign rd_idx = rd_sym_i[SYMBOL_BITS-1:0];

  // clamp length, drop code bits above it
  always_comb begin
    len_sat = (wr_len_i > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : wr_len_i;
    if (len_sat >= LEN_W'(CODE_W)) begin
      code_msk = wr_code_i;
    end else begin
      code_msk = wr_code_i & CODE_W'((17'd1 << len_sat) - 17'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx] <= {code_msk, len_sat};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q.valid <= valid_q[rd_idx];
      {rd_q.code, rd_q.len} <= mem_q[rd_idx];
    end
  end

  assign rd_o = rd_q;

endmodule

[src/huffman_code_packer_core.sv]
// Path: an accepted word is registered in stage 1 (word register and table
//   read); its results are then registered into the output buffer.
// Throughput: one input word per cycle while each yields at most one byte
//   and the receiver does not stall; a word that completes two bytes holds the
//   input until the last byte of the two-slot byte-wide output buffer is taken.
// Reset: async, active low. Table valid flags and the bit accumulator clear at
//   once; no clearing pass. Code storage holds garbage until loaded.
module huffman_code_packer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  symbol_i,
  input  logic [15:0] code_word_i,
  input  logic [4:0]  code_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        error_o,
  output logic        last_o
);
  import hcp_pkg::*;

  // ---------------------------------------------------------------------------
  // Stage 0: accept, table write for loads, registered table read for all.
  // ---------------------------------------------------------------------------
  logic   in_acc;
  entry_t ent;

  assign in_acc = in_valid_i && !in_stall_o;

  hcp_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (in_acc && (mode_i == MODE_LOAD)),
    .wr_sym_i (symbol_i),
    .wr_code_i(code_word_i),
    .wr_len_i (code_length_i),
    .rd_en_i  (in_acc),
    .rd_sym_i (symbol_i),
    .rd_o     (ent)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: word register; packs against the accumulator when the output
  // buffer drains.
  // ---------------------------------------------------------------------------
  logic             s1_valid_q;
  logic [1:0]       s1_mode_q;
  logic             s1_move;

  logic [PEND_W-1:0] pend_bits_q, pend_bits_d;
  logic [CNT_W-1:0]  pend_cnt_q, pend_cnt_d;

  // output buffer: slot 0 is the head
  logic [7:0] ob_byte_q [2];
  logic [1:0] ob_err_q, ob_last_q;
  logic [1:0] ob_cnt_q;
  logic       out_pop;

  assign out_pop    = out_valid_o && !out_stall_i;
  // buffer must be empty (or emptying) before a word's results go in
  assign s1_move    = s1_valid_q && ((ob_cnt_q == 2'd0) || ((ob_cnt_q == 2'd1) && out_pop));
  assign in_stall_o = s1_valid_q && !s1_move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_mode_q <= mode_i;
    end
  end

  // pack logic
  logic [ACC_W-1:0] acc;
  logic [LEN_W-1:0] total;
  logic [1:0]       res_n;
  logic [7:0]       res_byte [2];
  logic             res_err;

  always_comb begin
    acc         = (ACC_W'(pend_bits_q) << ent.len) | ACC_W'(ent.code);
    total       = LEN_W'(pend_cnt_q) + ent.len;
    res_n       = 2'd0;
    res_err     = 1'b0;
    res_byte[0] = 8'd0;
    res_byte[1] = 8'd0;
    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;
    case (s1_mode_q)
      MODE_ENCODE: begin
        if (!ent.valid) begin
          // unknown symbol: flag it, accumulator untouched
          res_n   = 2'd1;
          res_err = 1'b1;
        end else begin
          // total never reaches 24, so at most two bytes complete
          res_n       = total[4:3];
          res_byte[0] = 8'(acc >> (total - LEN_W'(8)));
          res_byte[1] = 8'(acc >> (total - LEN_W'(16)));
          pend_cnt_d  = total[2:0];
          pend_bits_d = PEND_W'(acc) & PEND_W'((8'd1 << total[2:0]) - 8'd1);
        end
      end
      MODE_FLUSH: begin
        if (pend_cnt_q != '0) begin
          res_n       = 2'd1;
          res_byte[0] = 8'({1'b0, pend_bits_q} << (4'd8 - {1'b0, pend_cnt_q}));
          pend_bits_d = '0;
          pend_cnt_d  = '0;
        end
      end
      default: begin
        // loads act in stage 0; unused mode does nothing
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
    end else if (s1_move) begin
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output buffer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_cnt_q <= 2'd0;
    end else if (s1_move) begin
      ob_cnt_q <= res_n;
    end else if (out_pop) begin
      ob_cnt_q <= ob_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      ob_byte_q[0] <= res_byte[0];
      ob_byte_q[1] <= res_byte[1];
      ob_err_q     <= {1'b0, res_err};
      ob_last_q    <= {(res_n == 2'd2), (res_n == 2'd1)};
    end else if (out_pop) begin
      ob_byte_q[0] <= ob_byte_q[1];
      ob_err_q[0]  <= ob_err_q[1];
      ob_last_q[0] <= ob_last_q[1];
    end
  end

  assign out_valid_o = (ob_cnt_q != 2'd0);
  assign out_byte_o  = ob_byte_q[0];
  assign error_o     = ob_err_q[0];
  assign last_o      = ob_last_q[0];

endmodule

[src/hcp_checker.sv]
module hcp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  out_byte_o,
  input logic        error_o,
  input logic        last_o
);

  // an error word is a lone, empty result
  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> last_o && (out_byte_o == 8'd0))
    else $error("error word not last or not zero");

  // second byte of a pair is ready right behind the first
  a_pair_b2b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o && !error_o)
    else $error("second byte of pair missing");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(out_byte_o) && $stable(error_o) && $stable(last_o))
    else $error("output word changed under stall");

  // input only backs up while the output side holds a word
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with output empty");

endmodule

bind huffman_code_packer_core hcp_checker u_hcp_checker (.*);
